// ===== src/fixed_width_decimal_formatter_top_assert.svh =====
// Assertion macros used by the formatter controller.
// Requires clk_i and rst_ni in the scope of every use.
`ifndef FIXED_WIDTH_DECIMAL_FORMATTER_TOP_ASSERT_SVH
`define FIXED_WIDTH_DECIMAL_FORMATTER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FWDF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fwdf assertion failed");

// Next-cycle implication, checked out of reset.
`define FWDF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fwdf assertion failed");

`endif

// ===== src/fwdf_pkg.sv =====
// Shared constants, types and the power-of-ten table of the decimal formatter.
// No dependencies.
`default_nettype none

package fwdf_pkg;

  localparam int MAX_DIGITS    = 7;
  localparam int VALUE_BITS    = 32;
  localparam int VALUE_FIELD_W = 32;
  localparam int CNT_W         = 3;
  localparam int CHAR_W        = 8;

  localparam int IN_W          = VALUE_FIELD_W + CNT_W + 1;
  localparam int IN_TDATA_W    = ((IN_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W   = ((CHAR_W + 7) / 8) * 8;

  // Digits kept below the top position.
  localparam int BCD_DIGITS    = (MAX_DIGITS > 1) ? MAX_DIGITS - 1 : 1;
  localparam longint POW_MAX   = 10 ** (MAX_DIGITS - 1);
  localparam int DIV_W         = $clog2(POW_MAX + 1);
  localparam int IDX_W         = (BCD_DIGITS > 1) ? $clog2(BCD_DIGITS) : 1;
  localparam int BIT_CNT_W     = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;

  typedef struct packed {
    logic load;   // capture a new transaction
    logic step;   // one conversion bit
    logic emit;   // load the next character into the output register
  } fwdf_cmd_t;

  typedef struct packed {
    logic cnt_zero;  // incoming digit count is zero
    logic last;      // character about to be emitted is the final one
  } fwdf_sts_t;

  // 10^k for k = 0 .. MAX_DIGITS-1, a small constant mux.
  function automatic logic [DIV_W-1:0] pow10_f(input logic [CNT_W-1:0] k);
    logic [DIV_W-1:0] p;
    logic [DIV_W-1:0] res;
    p   = DIV_W'(1);
    res = DIV_W'(1);
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (k == CNT_W'(i)) res = p;
      p = DIV_W'(p * DIV_W'(10));
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== src/fixed_width_decimal_formatter_top.sv =====
// Fixed-width decimal formatter, top level: stream ports, controller and datapath.
// Depends on fwdf_pkg, fwdf_ctrl and fwdf_dp.
//
// Each input transaction carries a 32-bit unsigned value, a digit count (1..7)
// and a keep-zeros flag; the block returns that many ASCII characters, most
// significant position first, tlast on the final one. Leading zero positions are
// sent as spaces unless keep-zeros is set; the final position is always a digit.
// If the value does not fit, the top position carries the wrapped code
// (value / 10^(count-1) + 48) mod 256. A count of zero is taken and produces
// nothing. Timing: after a transaction is accepted the datapath runs one
// restoring-division step and one double-dabble step per value bit, then emits
// one character per cycle while the sink is ready. The next transaction is taken
// the cycle after the last character enters the output register, so a steady
// stream is set by the 32-step bit-serial conversion plus the emission of its
// characters. The output register lets the last character wait for the sink
// while the next value is already converting.
`default_nettype none

module fixed_width_decimal_formatter_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // [31:0] value, [34:32] digit_count, [35] keep_zeros, [39:36] zero
  input  wire logic [fwdf_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [7:0] character
  output logic [fwdf_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  output logic                                 m_axis_tlast_o,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i
);
  import fwdf_pkg::*;

  fwdf_cmd_t         cmd;
  fwdf_sts_t         sts;
  logic [CHAR_W-1:0] out_char;

  // Sequencing: idle / convert / emit, plus the output valid flag.
  fwdf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Quotient and BCD conversion, blanking, output character register.
  fwdf_dp u_dp (
    .clk_i     (clk_i),
    .in_data_i (s_axis_tdata_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .char_o    (out_char),
    .last_o    (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = OUT_TDATA_W'(out_char);

endmodule

`default_nettype wire

// ===== src/fwdf_ctrl.sv =====
// Controller of the decimal formatter: state machine, bit counter, output valid.
// Depends on fwdf_pkg and fixed_width_decimal_formatter_top_assert.svh.
`default_nettype none

`include "fixed_width_decimal_formatter_top_assert.svh"

module fwdf_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_tvalid_i,
  output logic                    s_tready_o,
  output logic                    m_tvalid_o,
  input  wire logic               m_tready_i,
  input  wire fwdf_pkg::fwdf_sts_t sts_i,
  output fwdf_pkg::fwdf_cmd_t     cmd_o
);
  import fwdf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [BIT_CNT_W-1:0] bit_cnt_q, bit_cnt_d;
  logic                 out_vld_q, out_vld_d;
  logic                 in_fire;
  logic                 slot_free;

  assign s_tready_o = (state_q == ST_IDLE);
  assign in_fire    = s_tvalid_i && s_tready_o;
  assign slot_free  = !out_vld_q || m_tready_i;
  assign m_tvalid_o = out_vld_q;

  always_comb begin
    state_d   = state_q;
    bit_cnt_d = bit_cnt_q;
    cmd_o     = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && !sts_i.cnt_zero) begin
          cmd_o.load = 1'b1;
          bit_cnt_d  = '0;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.step = 1'b1;
        if (bit_cnt_q == BIT_CNT_W'(VALUE_BITS - 1)) begin
          bit_cnt_d = '0;
          state_d   = ST_EMIT;
        end else begin
          bit_cnt_d = bit_cnt_q + 1'b1;
        end
      end
      ST_EMIT: begin
        cmd_o.emit = slot_free;
        if (slot_free && sts_i.last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.emit) out_vld_d = 1'b1;
    else if (m_tready_i) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      bit_cnt_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Conversion never overlaps emission or a new load.
  `FWDF_ASSERT_IMP(a_conv_no_emit, state_q == ST_CONV, !cmd_o.emit && !cmd_o.load)
  // Bit counter only runs during conversion.
  `FWDF_ASSERT_IMP(a_cnt_idle, state_q != ST_CONV, bit_cnt_q == '0)
  // Emitting the final character returns to idle with the output occupied.
  `FWDF_ASSERT_NXT(a_last_idle, cmd_o.emit && sts_i.last, state_q == ST_IDLE && out_vld_q)

endmodule

`default_nettype wire

// ===== src/fwdf_dp.sv =====
// Datapath of the decimal formatter: shared bit-serial quotient and BCD conversion,
// digit selection with blanking, output character register. Depends on fwdf_pkg.
`default_nettype none

module fwdf_dp (
  input  wire logic                           clk_i,
  input  wire logic [fwdf_pkg::IN_TDATA_W-1:0] in_data_i,
  input  wire fwdf_pkg::fwdf_cmd_t             cmd_i,
  output fwdf_pkg::fwdf_sts_t                 sts_o,
  output logic [fwdf_pkg::CHAR_W-1:0]         char_o,
  output logic                                last_o
);
  import fwdf_pkg::*;

  logic [VALUE_FIELD_W-1:0] in_value;
  logic [CNT_W-1:0]         in_cnt;
  logic                     in_keep;
  logic [CNT_W-1:0]         cnt_clamp;
  logic [CNT_W-1:0]         top_k;

  logic [VALUE_BITS-1:0]    val_q;
  logic [DIV_W-1:0]         div_q;
  logic [DIV_W-1:0]         rem_q, rem_d;
  logic [DIV_W:0]           trial;
  logic                     qbit;
  logic [CHAR_W-1:0]        quo_q;
  logic                     qnz_q;
  logic [3:0]               bcd_q [BCD_DIGITS];
  logic [3:0]               adj   [BCD_DIGITS];
  logic                     shown_q;
  logic                     top_q;
  logic                     kzero_q;
  logic [IDX_W-1:0]         idx_q;

  logic [3:0]               digit;
  logic                     show;
  logic [CHAR_W-1:0]        char_d;
  logic                     last_d;

  assign in_value = in_data_i[VALUE_FIELD_W-1:0];
  assign in_cnt   = in_data_i[VALUE_FIELD_W +: CNT_W];
  assign in_keep  = in_data_i[VALUE_FIELD_W + CNT_W];

  assign cnt_clamp = (in_cnt > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS) : in_cnt;
  assign top_k     = cnt_clamp - 1'b1;

  // Restoring division by 10^k, one bit per step.
  assign trial = {rem_q, val_q[VALUE_BITS-1]};
  assign qbit  = (trial >= {1'b0, div_q});
  assign rem_d = qbit ? DIV_W'(trial - {1'b0, div_q}) : trial[DIV_W-1:0];

  // Double-dabble correction on the low digits.
  always_comb begin
    for (int j = 0; j < BCD_DIGITS; j++) begin
      adj[j] = (bcd_q[j] >= 4'd5) ? bcd_q[j] + 4'd3 : bcd_q[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q   <= in_value[VALUE_BITS-1:0];
      div_q   <= pow10_f(top_k);
      rem_q   <= '0;
      quo_q   <= '0;
      qnz_q   <= 1'b0;
      shown_q <= in_keep;
      top_q   <= 1'b1;
      kzero_q <= (top_k == '0);
      idx_q   <= IDX_W'(top_k - 1'b1);
      for (int j = 0; j < BCD_DIGITS; j++) bcd_q[j] <= '0;
    end else if (cmd_i.step) begin
      val_q <= {val_q[VALUE_BITS-2:0], 1'b0};
      rem_q <= rem_d;
      quo_q <= {quo_q[CHAR_W-2:0], qbit};
      qnz_q <= qnz_q | qbit;
      bcd_q[0] <= {adj[0][2:0], val_q[VALUE_BITS-1]};
      for (int j = 1; j < BCD_DIGITS; j++) bcd_q[j] <= {adj[j][2:0], adj[j-1][3]};
    end else if (cmd_i.emit) begin
      shown_q <= shown_q | show;
      if (top_q) top_q <= 1'b0;
      else       idx_q <= idx_q - 1'b1;
    end
  end

  // Character for the current position.
  assign digit = bcd_q[idx_q];

  always_comb begin
    if (top_q) begin
      show   = qnz_q || shown_q || kzero_q;
      char_d = show ? quo_q + CHAR_ZERO : CHAR_SPACE;
      last_d = kzero_q;
    end else begin
      show   = (digit != 4'd0) || shown_q || (idx_q == '0);
      char_d = show ? {4'd0, digit} + CHAR_ZERO : CHAR_SPACE;
      last_d = (idx_q == '0);
    end
  end

  assign sts_o.cnt_zero = (in_cnt == '0);
  assign sts_o.last     = last_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      char_o <= char_d;
      last_o <= last_d;
    end
  end

endmodule

`default_nettype wire

// ===== test/fixed_width_decimal_formatter_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for fixed_width_decimal_formatter_top: stream stimulus,
// a scoreboard that predicts the ASCII characters of each value, random idling.
// Depends on fwdf_pkg and the formatter RTL only.

module fixed_width_decimal_formatter_top_tb;
  import fwdf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;   // slack for the conversion; count 0 gives no tlast

  typedef struct {
    logic [CHAR_W-1:0] code;
    logic              last;
  } ascii_char_t;

  // Holds the characters still owed by the formatter, oldest first.
  class ascii_scoreboard;
    ascii_char_t pending_chars[$];
    int unsigned mismatches;

    function void log_mismatch(string msg);
      if (mismatches < 10) $display("mismatch: %s", msg);
      mismatches++;
    endfunction

    // Expected characters for one accepted value transaction.
    function void note_value(logic [31:0] value, logic [CNT_W-1:0] count, logic keep_zeros);
      longint unsigned rem;
      longint unsigned div;
      longint unsigned q;
      int unsigned     n;
      bit              shown;
      ascii_char_t     c;
      rem   = value;
      n     = count;
      shown = keep_zeros;
      if (n > MAX_DIGITS) n = MAX_DIGITS;
      if (n == 0) return;
      div = 1;
      for (int i = 1; i < n; i++) div *= 10;
      for (int i = 0; i < n; i++) begin
        q = rem / div;
        if (div == 1) shown = 1;   // final position always shows a digit
        if (q != 0 || shown) begin
          c.code = CHAR_W'(q + CHAR_ZERO);   // overflow wraps mod 256
          shown  = 1;
        end else begin
          c.code = CHAR_SPACE;
        end
        c.last = (i + 1 == n);
        pending_chars.push_back(c);
        rem = rem % div;
        if (div >= 10) div /= 10;
      end
    endfunction

    function void check_char(logic [CHAR_W-1:0] code, logic last);
      ascii_char_t exp_c;
      if (pending_chars.size() == 0) begin
        log_mismatch($sformatf("unexpected char 0x%02h last %0d", code, last));
        return;
      end
      exp_c = pending_chars.pop_front();
      if (code !== exp_c.code || last !== exp_c.last)
        log_mismatch($sformatf("char exp 0x%02h last %0d, got 0x%02h last %0d",
                               exp_c.code, exp_c.last, code, last));
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;

  ascii_scoreboard        char_board;
  int unsigned            idle_pct  = 0;   // sender gap probability, percent
  int unsigned            stall_pct = 0;   // sink stall probability, percent
  int unsigned            cycle_cnt = 0;

  fixed_width_decimal_formatter_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready)
  );

  always #6 clk_i = ~clk_i;

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("** fixed_width_decimal_formatter_top: FAILED **");
      $finish;
    end
  end

  // Sink: check each accepted character, then pick the next ready level.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      char_board.check_char(m_axis_tdata[CHAR_W-1:0], m_axis_tlast);
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic longint unsigned pow10(int unsigned e);
    longint unsigned p;
    p = 1;
    for (int i = 0; i < e; i++) p *= 10;
    return p;
  endfunction

  // Drive one value transaction and wait for the handshake.
  task automatic send_value(logic [31:0] value, logic [CNT_W-1:0] count, logic keep_zeros);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({keep_zeros, count, value});
    do @(posedge clk_i); while (!s_axis_tready);
    char_board.note_value(value, count, keep_zeros);
  endtask

  // Drop valid and hold until every owed character has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (char_board.pending_chars.size() != 0) @(posedge clk_i);
  endtask

  // Random value shaped around the digit count: fitting, boundary, overflowing.
  function automatic logic [31:0] pick_value(int unsigned n);
    longint unsigned span;
    span = pow10(n);
    case ($urandom_range(9))
      0, 1, 2: return $urandom;
      3, 4, 5: return $urandom_range(0, 32'(span - 1));
      6:       return $urandom_range(0, 99);
      7:       return ($urandom_range(1)) ? 32'(span - 1) : 32'(span / 10);
      8:       return $urandom_range(32'(span), 32'(span * 300));
      default: return $urandom >> $urandom_range(31);
    endcase
  endfunction

  task automatic run_random(int unsigned items);
    int unsigned n;
    for (int i = 0; i < items; i++) begin
      n = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 7);
      send_value(pick_value(n), CNT_W'(n), 1'($urandom));
    end
  endtask

  initial begin
    char_board = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero in every width, both blanking modes.
    for (int c = 1; c <= MAX_DIGITS; c++) begin
      send_value(32'd0, CNT_W'(c), 1'b0);
      send_value(32'd0, CNT_W'(c), 1'b1);
    end
    send_value(32'd1234567, 3'd7, 1'b0);
    send_value(32'd305, 3'd7, 1'b0);       // interior zero stays a digit
    send_value(32'd12345678, 3'd7, 1'b0);  // top digit overflows
    send_value(32'hFFFF_FFFF, 3'd7, 1'b0);
    send_value(32'hFFFF_FFFF, 3'd1, 1'b1);
    send_value(32'd9, 3'd1, 1'b0);         // single position, fits
    send_value(32'd10, 3'd1, 1'b0);        // single position, wraps
    send_value(32'd256, 3'd1, 1'b0);       // wrapped code looks like a zero
    send_value(32'd2405, 3'd2, 1'b0);      // wrapped top digit looks like a space
    send_value(32'd77, 3'd0, 1'b1);        // zero count, no characters
    send_value(32'hAAAA_5555, 3'd0, 1'b0);

    // Random phases under different idling.
    idle_pct = 0;  stall_pct = 0;  run_random(90);
    wait_drained();   // sender pause until every result is back
    idle_pct = 64; stall_pct = 0;  run_random(90);
    idle_pct = 0;  stall_pct = 64; run_random(90);
    idle_pct = 12; stall_pct = 12; run_random(90);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (char_board.mismatches == 0 && char_board.pending_chars.size() == 0) begin
      $display("** fixed_width_decimal_formatter_top: PASSED **");
    end else begin
      $display("** fixed_width_decimal_formatter_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/fwdf_pkg.sv
src/fwdf_ctrl.sv
src/fwdf_dp.sv
src/fixed_width_decimal_formatter_top.sv
test/fixed_width_decimal_formatter_top_tb.sv
